FILE: src/sds_pkg.sv
// Shared constants and types for the per-channel sample-due scheduler.
// No dependencies; used by the top level and sds_conv.
package sds_pkg;

  localparam int NUM_CHANNELS_DEF = 8;

  localparam int PERIOD_W = 25;
  localparam int TIME_W   = 17;
  localparam int CHAN_W   = 8;
  localparam int FUNC_W   = 2;
  localparam int CFG_IDX_W = 2;

  localparam int SECS_PER_DAY  = 86400;
  localparam int SECS_PER_HOUR = 3600;
  localparam int SECS_PER_MIN  = 60;

  localparam logic [PERIOD_W-1:0] SHORTEST_RST = 25'd1;
  localparam logic [PERIOD_W-1:0] LONGEST_RST  = 25'd86400;
  localparam logic [PERIOD_W-1:0] DEFAULT_RST  = 25'd10;

  localparam logic [FUNC_W-1:0] FUNC_POLL = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INIT = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_SHORTEST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LONGEST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT  = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_SUM  = 4'b0100,
    S_EXEC = 4'b1000
  } state_t;

  // hour in the lowest bits, matching the tdata layout above the channel
  typedef struct packed {
    logic [7:0] p_seconds;
    logic [7:0] p_minutes;
    logic [7:0] p_hours;
    logic [7:0] p_days;
    logic [5:0] second;
    logic [5:0] minute;
    logic [4:0] hour;
  } time_fields_t;

endpackage

FILE: src/per_channel_sample_due_scheduler.sv
// Per-channel sample-due scheduler: top level, sequencer and table update.
// Depends on sds_pkg, sds_conv and sds_ram.
//
// Usage:
//   s_* takes one command beat: s_tuser carries func (0 poll, 1 set period,
//   2 initialise), s_tdata the channel, time of day and period fields.
//   m_* returns exactly one beat per command: status (0 ok) and due_time.
//   cfg_* writes shortest, longest and default period (index 0, 1, 2); it is
//   always ready and must only be used while no command is in flight.
// Timing:
//   m_tvalid rises after the command beat is accepted and has passed the steps
//   READ (table read with field products), SUM (sum) and EXEC (compare and write back).
//   One command is handled at a time: no new beat is accepted until the current
//   one has finished its read-modify-write of the channel table RAM.
//   The output register lets the next command be accepted while a result waits.
// Reset:
//   rst clears all channels to uninitialised and the registers to 1, 86400
//   and 10. A poll uses table RAM contents only on an initialised channel.
// Stall:
//   If a result is still waiting and m_tready is low, the finished command holds
//   in the last step and s_tready stays low until the waiting result is taken.
module per_channel_sample_due_scheduler #(
  parameter int NUM_CHANNELS = sds_pkg::NUM_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [63:0]                       s_tdata,  // channel, hour, minute, second,
                                                      // period_days, period_hours,
                                                      // period_minutes, period_seconds
  input  logic [sds_pkg::FUNC_W-1:0]        s_tuser,  // func
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [23:0]                       m_tdata,  // status, due_time
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [sds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sds_pkg::PERIOD_W-1:0]      cfg_data
);
  localparam int PW = sds_pkg::PERIOD_W;
  localparam int TW = sds_pkg::TIME_W;
  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int EW = TW + 2;
  localparam int RW = PW + TW;
  localparam logic [EW-1:0] DAY_END = EW'(sds_pkg::SECS_PER_DAY - 1);

  sds_pkg::state_t state;

  logic [PW-1:0] shortest, longest, dflt;

  logic [sds_pkg::FUNC_W-1:0] cap_func;
  logic [sds_pkg::CHAN_W-1:0] cap_chan;
  sds_pkg::time_fields_t      cap_fields;

  logic [NUM_CHANNELS-1:0] chan_ready;

  logic [TW-1:0] now;
  logic [PW-1:0] period;
  logic [RW-1:0] rd_entry;
  logic [PW-1:0] old_period;
  logic [TW-1:0] old_last;

  logic          chan_ok, out_free, finish, is_ready, in_rng, due;
  logic [EW-1:0] wrap_diff;
  logic [TW-1:0] fwd_diff;
  logic          wr_en, status_next;
  logic [RW-1:0] wr_entry;
  logic [TW-1:0] due_next;
  logic [AW-1:0] addr;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == sds_pkg::S_IDLE);
  assign out_free  = !m_tvalid || m_tready;
  assign finish    = (state == sds_pkg::S_EXEC) && out_free;
  assign addr      = cap_chan[AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      shortest <= sds_pkg::SHORTEST_RST;
      longest  <= sds_pkg::LONGEST_RST;
      dflt     <= sds_pkg::DEFAULT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sds_pkg::REG_SHORTEST: shortest <= cfg_data;
        sds_pkg::REG_LONGEST:  longest  <= cfg_data;
        sds_pkg::REG_DEFAULT:  dflt     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      cap_func   <= s_tuser;
      cap_chan   <= s_tdata[7:0];
      cap_fields <= s_tdata[56:8];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sds_pkg::S_IDLE;
    end else begin
      unique case (state)
        sds_pkg::S_IDLE: if (s_tvalid) state <= sds_pkg::S_READ;
        sds_pkg::S_READ: state <= sds_pkg::S_SUM;
        sds_pkg::S_SUM:  state <= sds_pkg::S_EXEC;
        sds_pkg::S_EXEC: if (out_free) state <= sds_pkg::S_IDLE;
        default:         state <= sds_pkg::S_IDLE;
      endcase
    end
  end

  sds_conv u_conv (
    .clk    (clk),
    .fields (cap_fields),
    .now    (now),
    .period (period)
  );

  sds_ram #(
    .WIDTH (RW),
    .DEPTH (NUM_CHANNELS)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (addr),
    .wdata (wr_entry),
    .re    (state == sds_pkg::S_READ),
    .raddr (addr),
    .rdata (rd_entry)
  );

  assign old_period = rd_entry[RW-1:TW];
  assign old_last   = rd_entry[TW-1:0];

  assign chan_ok   = {1'b0, cap_chan} < 9'(NUM_CHANNELS);
  assign is_ready  = chan_ok && chan_ready[addr];
  assign in_rng    = (period <= longest) && (period >= shortest);
  // past midnight: (86400-1) - last + now; a negative value wraps huge, always due
  assign wrap_diff = DAY_END + EW'(now) - EW'(old_last);
  assign fwd_diff  = now - old_last;
  assign due       = (now >= old_last) ? (PW'(fwd_diff) >= old_period)
                                       : (wrap_diff[EW-1] ||
                                          (PW'(wrap_diff[EW-2:0]) >= old_period));

  always_comb begin
    wr_en       = 1'b0;
    wr_entry    = rd_entry;
    status_next = 1'b1;
    due_next    = '0;
    case (cap_func)
      sds_pkg::FUNC_POLL: begin
        if (is_ready && due) begin
          wr_en       = finish;
          wr_entry    = {old_period, now};
          status_next = 1'b0;
          due_next    = now;
        end
      end
      sds_pkg::FUNC_SET: begin
        if (chan_ok && in_rng) begin
          wr_en       = finish;
          wr_entry    = {period, old_last};
          status_next = 1'b0;
        end
      end
      sds_pkg::FUNC_INIT: begin
        if (chan_ok) begin
          wr_en       = finish;
          wr_entry    = {(in_rng ? period : dflt), now};
          status_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_ready <= '0;
    end else if (finish && chan_ok && (cap_func == sds_pkg::FUNC_INIT)) begin
      chan_ready[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {6'd0, due_next, status_next};
    end
  end
endmodule

FILE: src/sds_ram.sv
// Generic simple dual-port RAM, one write port and one registered read port.
// No dependencies.
module sds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic                                          re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

FILE: src/sds_conv.sv
// Two-stage conversion of time-of-day and period fields into seconds.
// Depends on sds_pkg.
module sds_conv (
  input  logic                          clk,
  input  sds_pkg::time_fields_t         fields,
  output logic [sds_pkg::TIME_W-1:0]    now,
  output logic [sds_pkg::PERIOD_W-1:0]  period
);
  localparam int PW = sds_pkg::PERIOD_W;
  localparam int TW = sds_pkg::TIME_W;

  logic [TW-1:0] t_hour, t_min, t_sec;
  logic [PW-1:0] p_day, p_hour, p_min, p_sec;

  // stage 1: products
  always_ff @(posedge clk) begin
    t_hour <= TW'(fields.hour) * TW'(sds_pkg::SECS_PER_HOUR);
    t_min  <= TW'(fields.minute) * TW'(sds_pkg::SECS_PER_MIN);
    t_sec  <= TW'(fields.second);
    p_day  <= PW'(fields.p_days) * PW'(sds_pkg::SECS_PER_DAY);
    p_hour <= PW'(fields.p_hours) * PW'(sds_pkg::SECS_PER_HOUR);
    p_min  <= PW'(fields.p_minutes) * PW'(sds_pkg::SECS_PER_MIN);
    p_sec  <= PW'(fields.p_seconds);
  end

  // stage 2: sums
  always_ff @(posedge clk) begin
    now    <= t_hour + t_min + t_sec;
    period <= p_day + p_hour + p_min + p_sec;
  end
endmodule
